// ----- sv/assert_macros.svh -----
// assertion macros shared by the encoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CFAE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the trigger, outside reset
`define CFAE_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ----- sv/cfae_pkg.sv -----
// types, constants and helpers shared by the frame-to-ascii encoder
`timescale 1ns / 1ps

package cfae_pkg;

  // type letters
  localparam logic [6:0] CHAR_STD_DATA = 7'h74;  // t
  localparam logic [6:0] CHAR_STD_RTR  = 7'h72;  // r
  localparam logic [6:0] CHAR_EXT_DATA = 7'h54;  // T
  localparam logic [6:0] CHAR_EXT_RTR  = 7'h52;  // R

  // identifier bit positions
  localparam int unsigned ID_EXT_BIT = 31;
  localparam int unsigned ID_RTR_BIT = 30;
  localparam int unsigned ID_ERR_BIT = 29;

  // id digit counts and data byte limit
  localparam logic [4:0] DIGITS_EXT  = 5'd8;
  localparam logic [4:0] DIGITS_STD  = 5'd3;
  localparam logic [6:0] MAX_BYTES   = 7'd8;
  localparam logic [6:0] MAX_LEN_RST = 7'd8;

  // queue depth between front and back
  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  // classified frame handed from front to back
  typedef struct packed {
    logic [6:0]  letter;
    logic [31:0] idv;
    logic        ext;       // eight id digits, else three
    logic [3:0]  dlc;
    logic [63:0] data;
    logic [4:0]  last_pos;  // index of the final character
  } desc_t;

  // nibble to uppercase hex character
  function automatic logic [6:0] hex_char(input logic [3:0] v);
    logic [6:0] v7;
    v7 = {3'b000, v};
    if (v < 4'd10) return 7'h30 + v7;
    else return 7'h37 + v7;
  endfunction

endpackage

// ----- sv/cfae_if.sv -----
// valid/ready channels for frames in and characters out
`timescale 1ns / 1ps

// frame word channel
interface cfae_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] can_id;
  logic [3:0]  dlc;
  logic [63:0] data;

  modport source (output valid, output can_id, output dlc, output data, input ready);
  modport sink   (input valid, input can_id, input dlc, input data, output ready);
endinterface

// character word channel
interface cfae_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_out;
  logic       last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface

// ----- sv/cfae_front.sv -----
// front end: accepts frame words and classifies them into descriptors
`timescale 1ns / 1ps

module cfae_front (
  input  logic            clk,
  input  logic            rst_n,
  cfae_in_if.sink         in_frame,
  input  logic [6:0]      max_len,
  output logic            desc_valid,
  output cfae_pkg::desc_t desc,
  input  logic            desc_ready
);

  logic            valid_r;
  logic            valid_nxt;
  cfae_pkg::desc_t desc_r;
  cfae_pkg::desc_t desc_nxt;
  logic            accept;

  logic        remote;
  logic        err;
  logic        ext_or_err;
  logic [6:0]  dlc_w;
  logic [6:0]  min_len;
  logic [3:0]  len;
  logic [4:0]  digits;

  // stage holds one descriptor until the queue takes it
  assign in_frame.ready = !valid_r || desc_ready;
  assign accept         = in_frame.valid && in_frame.ready;
  assign desc_valid     = valid_r;
  assign desc           = desc_r;

  // classify the frame
  always_comb begin
    remote     = (max_len == cfae_pkg::MAX_LEN_RST) && in_frame.can_id[cfae_pkg::ID_RTR_BIT];
    err        = in_frame.can_id[cfae_pkg::ID_ERR_BIT];
    ext_or_err = in_frame.can_id[cfae_pkg::ID_EXT_BIT] || err;
    dlc_w      = {3'b000, in_frame.dlc};
    min_len    = (dlc_w < max_len) ? dlc_w : max_len;
    if (remote) len = 4'd0;
    else if (min_len > cfae_pkg::MAX_BYTES) len = cfae_pkg::MAX_BYTES[3:0];
    else len = min_len[3:0];
    digits = ext_or_err ? cfae_pkg::DIGITS_EXT : cfae_pkg::DIGITS_STD;

    desc_nxt.ext  = ext_or_err;
    desc_nxt.dlc  = in_frame.dlc;
    desc_nxt.data = in_frame.data;
    if (ext_or_err) begin
      desc_nxt.letter = remote ? cfae_pkg::CHAR_EXT_RTR : cfae_pkg::CHAR_EXT_DATA;
      desc_nxt.idv    = err ? {2'b00, in_frame.can_id[29:0]} : {3'b000, in_frame.can_id[28:0]};
    end else begin
      desc_nxt.letter = remote ? cfae_pkg::CHAR_STD_RTR : cfae_pkg::CHAR_STD_DATA;
      desc_nxt.idv    = {21'd0, in_frame.can_id[10:0]};
    end
    desc_nxt.last_pos = digits + 5'd1 + {len, 1'b0};
  end

  // stage valid flag
  always_comb begin
    valid_nxt = valid_r;
    if (accept) valid_nxt = 1'b1;
    else if (desc_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  // descriptor payload
  always_ff @(posedge clk) begin
    if (accept) desc_r <= desc_nxt;
  end

endmodule

// ----- sv/cfae_queue.sv -----
// two-entry descriptor queue between front and back
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cfae_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cfae_pkg::desc_t push_desc,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output cfae_pkg::desc_t head
);

  cfae_pkg::desc_t mem [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign not_full  = count_r != cfae_pkg::QUEUE_DEPTH;
  assign not_empty = count_r != 2'd0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr_r];

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_desc;
  end

  `CFAE_ASSERT(a_no_push_full, !(push && !not_full), "push into full queue")
  `CFAE_ASSERT(a_no_pop_empty, !(pop && !not_empty), "pop from empty queue")

endmodule

// ----- sv/cfae_back.sv -----
// back end: walks a descriptor and emits one character per cycle while the output is not stalled
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cfae_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            desc_valid,
  input  cfae_pkg::desc_t desc,
  output logic            desc_pop,
  cfae_out_if.source      out_char
);

  logic [4:0] pos_r;
  logic [4:0] pos_nxt;
  logic       valid_r;
  logic       valid_nxt;
  logic [6:0] char_r;
  logic       last_r;

  logic       advance;
  logic       is_last;
  logic [4:0] digits;
  logic [4:0] id_idx;
  logic [4:0] byte_pos;
  logic [3:0] data_nib;
  logic [6:0] char_sel;

  assign out_char.valid    = valid_r;
  assign out_char.char_out = char_r;
  assign out_char.last     = last_r;

  assign advance  = desc_valid && (!valid_r || out_char.ready);
  assign is_last  = pos_r == desc.last_pos;
  assign desc_pop = advance && is_last;

  // pick the character at the current position
  always_comb begin
    digits   = desc.ext ? cfae_pkg::DIGITS_EXT : cfae_pkg::DIGITS_STD;
    id_idx   = digits - pos_r;
    byte_pos = pos_r - digits - 5'd2;
    data_nib = {byte_pos[3:1], ~byte_pos[0]};
    priority if (pos_r == 5'd0) begin
      char_sel = desc.letter;
    end else if (pos_r <= digits) begin
      char_sel = cfae_pkg::hex_char(desc.idv[{id_idx[2:0], 2'b00} +: 4]);
    end else if (pos_r == digits + 5'd1) begin
      char_sel = cfae_pkg::hex_char(desc.dlc);
    end else begin
      char_sel = cfae_pkg::hex_char(desc.data[{data_nib, 2'b00} +: 4]);
    end
  end

  // position counter and output register flag
  always_comb begin
    pos_nxt   = pos_r;
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
      pos_nxt   = is_last ? 5'd0 : pos_r + 5'd1;
    end else if (out_char.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 5'd0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (advance) begin
      char_r <= char_sel;
      last_r <= is_last;
    end
  end

  `CFAE_ASSERT(a_pos_in_frame, !desc_valid || (pos_r <= desc.last_pos), "position past frame end")
  `CFAE_ASSERT_NEXT(a_pos_wraps, desc_pop, (pos_r == 5'd0) && last_r, "frame end not restarted")

endmodule

// ----- sv/can_frame_to_ascii_encoder_core.sv -----
// top level of the can frame to serial-line ascii encoder
`timescale 1ns / 1ps

// Turns each accepted CAN frame word into slcan-style ASCII text, one
// character per output word, with last set on the final character. A frame
// gives between 5 and 26 characters (type letter, 3 or 8 id digits, length
// digit, two digits per data byte), and the back-end sequencer emits one
// character per cycle while the output is ready, so a queued frame follows
// the previous one with no gap. The front end classifies the next frame and
// a two-entry queue holds it while the current one is being sent. max_len
// is written through cfg_we/cfg_wdata and resets to 8; the user must write
// it only while idle, since the block itself does not enforce this.
module can_frame_to_ascii_encoder_core (
  input  logic       clk,
  input  logic       rst_n,
  cfae_in_if.sink    in_frame,
  cfae_out_if.source out_char,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  logic [6:0]      max_len_r;
  logic [6:0]      max_len_nxt;
  logic            f_valid;
  cfae_pkg::desc_t f_desc;
  logic            q_not_full;
  logic            q_not_empty;
  logic            q_pop;
  cfae_pkg::desc_t q_head;

  // configuration register
  assign max_len_nxt = cfg_we ? cfg_wdata : max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) max_len_r <= cfae_pkg::MAX_LEN_RST;
    else max_len_r <= max_len_nxt;
  end

  // front end
  cfae_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_frame   (in_frame),
    .max_len    (max_len_r),
    .desc_valid (f_valid),
    .desc       (f_desc),
    .desc_ready (q_not_full)
  );

  // descriptor queue, pushed only when it has room
  cfae_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid && q_not_full),
    .push_desc (f_desc),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back end
  cfae_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (q_not_empty),
    .desc       (q_head),
    .desc_pop   (q_pop),
    .out_char   (out_char)
  );

endmodule
